### rtl/core/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int unsigned MAX_WIDTH_PIXELS = 4096;
  localparam int unsigned MAX_HEIGHT_ROWS  = 4096;
  localparam int unsigned PLANE_COUNT      = 8;

  localparam int unsigned GROUP_PIXELS = 8;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned PLANE_SEL_W  = $clog2(PLANE_COUNT);

  localparam int unsigned WIDTH_W    = 13;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned PSTRIDE_W  = 12;
  localparam int unsigned SSTRIDE_W  = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned COL_W  = 9;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned BPR_W  = WIDTH_W - 3;

  localparam logic [COL_W:0] COL_LIMIT = {1'b0, {COL_W{1'b1}}};
  localparam logic [ROW_W:0] ROW_LIMIT = {1'b0, {ROW_W{1'b1}}};

  typedef logic [PIX_W-1:0]         pixel_t;
  typedef pixel_t [GROUP_PIXELS-1:0] pixel_group_t;
  typedef logic [GROUP_PIXELS-1:0]  plane_byte_t;
  typedef plane_byte_t [PLANE_COUNT-1:0] plane_group_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_GROUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_DIM     = 2'd1,
    STATUS_BAD_STRIDE  = 2'd2,
    STATUS_NOT_STARTED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_PIXELS      = 2'd0,
    CFG_HEIGHT_ROWS       = 2'd1,
    CFG_PLANE_ROW_STRIDE  = 2'd2,
    CFG_SOURCE_ROW_STRIDE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              emit_planes;
    logic [ADDR_W-1:0] byte_address;
    status_t           status;
    logic              frame_done;
  } ctrl_res_t;

endpackage

### rtl/core/c2p_in_if.sv
`timescale 1ns / 1ps

interface c2p_in_if
  import c2p_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   cmd;
  pixel_t pixel_0;
  pixel_t pixel_1;
  pixel_t pixel_2;
  pixel_t pixel_3;
  pixel_t pixel_4;
  pixel_t pixel_5;
  pixel_t pixel_6;
  pixel_t pixel_7;

  modport source (
    output valid, cmd, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7,
    output ready
  );
endinterface

### rtl/core/c2p_out_if.sv
`timescale 1ns / 1ps

interface c2p_out_if
  import c2p_pkg::*;
();
  logic              valid;
  logic              ready;
  plane_byte_t       plane_byte_0;
  plane_byte_t       plane_byte_1;
  plane_byte_t       plane_byte_2;
  plane_byte_t       plane_byte_3;
  plane_byte_t       plane_byte_4;
  plane_byte_t       plane_byte_5;
  plane_byte_t       plane_byte_6;
  plane_byte_t       plane_byte_7;
  logic [ADDR_W-1:0] byte_address;
  logic [1:0]        status;
  logic              frame_done;

  modport source (
    output valid, plane_byte_0, plane_byte_1, plane_byte_2, plane_byte_3,
           plane_byte_4, plane_byte_5, plane_byte_6, plane_byte_7,
           byte_address, status, frame_done,
    input  ready
  );
  modport sink (
    input  valid, plane_byte_0, plane_byte_1, plane_byte_2, plane_byte_3,
           plane_byte_4, plane_byte_5, plane_byte_6, plane_byte_7,
           byte_address, status, frame_done,
    output ready
  );
endinterface

### rtl/core/c2p_cfg_if.sv
`timescale 1ns / 1ps

interface c2p_cfg_if
  import c2p_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### rtl/core/c2p_lane.sv
`timescale 1ns / 1ps

module c2p_lane
  import c2p_pkg::*;
(
  input  pixel_group_t           pixels,
  input  logic [PLANE_SEL_W-1:0] plane_sel,
  output plane_byte_t            plane_byte
);

  logic [$clog2(PIX_W)-1:0] bit_pos;

  // even planes take the high nibble, odd planes the low one
  assign bit_pos = plane_sel[0] ? $clog2(PIX_W)'(plane_sel[PLANE_SEL_W-1:1])
                                : $clog2(PIX_W)'(NIBBLE_W) +
                                  $clog2(PIX_W)'(plane_sel[PLANE_SEL_W-1:1]);

  always_comb begin
    for (int p = 0; p < GROUP_PIXELS; p++) begin
      plane_byte[GROUP_PIXELS-1-p] = pixels[p][bit_pos];
    end
  end

endmodule

### rtl/core/c2p_ctrl.sv
`timescale 1ns / 1ps

module c2p_ctrl
  import c2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  c2p_cfg_if.sink    cfg,
  input  logic       acc,
  input  logic       cmd,
  output ctrl_res_t  res
);

  logic [WIDTH_W-1:0]   width_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic [PSTRIDE_W-1:0] pstride_r;
  logic [SSTRIDE_W-1:0] sstride_r;

  logic              armed_r, armed_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  logic [BPR_W-1:0] row_bytes;
  logic [COL_W:0]   next_col;
  logic [ROW_W:0]   next_row;
  logic             col_end;
  logic             row_end;
  status_t          check_status;

  assign cfg.ready = 1'b1;
  assign row_bytes = width_r[WIDTH_W-1:3];
  assign next_col  = {1'b0, col_r} + (COL_W+1)'(1);
  assign next_row  = {1'b0, row_r} + (ROW_W+1)'(1);
  assign col_end   = (next_col >= (COL_W+1)'(row_bytes)) || (next_col > COL_LIMIT);
  assign row_end   = (next_row >= height_r) || (next_row > ROW_LIMIT);

  always_comb begin
    if ((width_r == '0) || (width_r[2:0] != 3'd0) || (32'(width_r) > MAX_WIDTH_PIXELS) ||
        (height_r == '0) || (32'(height_r) > MAX_HEIGHT_ROWS)) begin
      check_status = STATUS_BAD_DIM;
    end else if ((pstride_r < PSTRIDE_W'(row_bytes)) || (sstride_r < width_r)) begin
      check_status = STATUS_BAD_STRIDE;
    end else begin
      check_status = STATUS_OK;
    end
  end

  always_comb begin
    armed_nxt            = armed_r;
    col_nxt              = col_r;
    row_nxt              = row_r;
    base_nxt             = base_r;
    res.emit_planes      = 1'b0;
    res.byte_address     = '0;
    res.status           = STATUS_OK;
    res.frame_done       = 1'b0;
    if (cmd == CMD_START) begin
      res.status = check_status;
      armed_nxt  = (check_status == STATUS_OK);
      col_nxt    = '0;
      row_nxt    = '0;
      base_nxt   = '0;
    end else if (!armed_r) begin
      res.status = STATUS_NOT_STARTED;
    end else begin
      res.emit_planes  = 1'b1;
      res.byte_address = base_r + ADDR_W'(col_r);
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          res.frame_done = 1'b1;
          armed_nxt      = 1'b0;
          row_nxt        = '0;
          base_nxt       = '0;
        end else begin
          row_nxt  = next_row[ROW_W-1:0];
          base_nxt = base_r + ADDR_W'(pstride_r);
        end
      end else begin
        col_nxt = next_col[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= '0;
      height_r  <= '0;
      pstride_r <= '0;
      sstride_r <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_WIDTH_PIXELS:      width_r   <= cfg.data[WIDTH_W-1:0];
        CFG_HEIGHT_ROWS:       height_r  <= cfg.data[HEIGHT_W-1:0];
        CFG_PLANE_ROW_STRIDE:  pstride_r <= cfg.data[PSTRIDE_W-1:0];
        CFG_SOURCE_ROW_STRIDE: sstride_r <= cfg.data[SSTRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
    end else if (acc) begin
      armed_r <= armed_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      base_r  <= base_nxt;
    end
  end

  a_done_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_done |-> (res.status == STATUS_OK) && res.emit_planes)
    else $error("frame end flagged on a transaction without plane data");

  a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.frame_done |=> !armed_r)
    else $error("still armed after the last group of the frame");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (col_r == '0) && (row_r == '0) && (base_r == '0))
    else $error("counters not cleared while disarmed");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (cmd == CMD_START) && (res.status == STATUS_OK) |=> armed_r)
    else $error("successful start did not arm the counters");

endmodule

### rtl/core/chunky_to_planar_dual_nibble_unit.sv
`timescale 1ns / 1ps
// An accepted input transaction's result is on out_ch in the cycle after it.
// Throughput: one transaction per cycle; the single output register takes a new
// result in the cycle its current one is taken, so in_ch stalls only with out_ch.
// Reset: synchronous, active low; clears the frame registers, counters, armed
// flag and output valid.

module chunky_to_planar_dual_nibble_unit
  import c2p_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  c2p_in_if.sink   in_ch,
  c2p_out_if.source out_ch,
  c2p_cfg_if.sink  cfg_ch
);

  logic         acc;
  pixel_group_t pix_grp;
  plane_group_t lane_byte;
  plane_group_t planes_nxt;
  ctrl_res_t    ctrl_res;

  logic              out_valid_r;
  plane_group_t      planes_r;
  logic [ADDR_W-1:0] addr_r;
  status_t           status_r;
  logic              done_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign pix_grp = {in_ch.pixel_7, in_ch.pixel_6, in_ch.pixel_5, in_ch.pixel_4,
                    in_ch.pixel_3, in_ch.pixel_2, in_ch.pixel_1, in_ch.pixel_0};

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
    c2p_lane u_lane (
      .pixels     (pix_grp),
      .plane_sel  (PLANE_SEL_W'(g)),
      .plane_byte (lane_byte[g])
    );
  end

  c2p_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .acc   (acc),
    .cmd   (in_ch.cmd),
    .res   (ctrl_res)
  );

  assign planes_nxt = ctrl_res.emit_planes ? lane_byte : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      planes_r <= planes_nxt;
      addr_r   <= ctrl_res.byte_address;
      status_r <= ctrl_res.status;
      done_r   <= ctrl_res.frame_done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.plane_byte_0 = planes_r[0];
  assign out_ch.plane_byte_1 = planes_r[1];
  assign out_ch.plane_byte_2 = planes_r[2];
  assign out_ch.plane_byte_3 = planes_r[3];
  assign out_ch.plane_byte_4 = planes_r[4];
  assign out_ch.plane_byte_5 = planes_r[5];
  assign out_ch.plane_byte_6 = planes_r[6];
  assign out_ch.plane_byte_7 = planes_r[7];
  assign out_ch.byte_address = addr_r;
  assign out_ch.status       = status_r;
  assign out_ch.frame_done   = done_r;

endmodule
